@@ hdl/rhsv_pkg.sv @@
// rhsv_pkg: types and constants shared by the RGB to HSV converter.
// No dependencies; every other file of the block uses it by scoped name.

package rhsv_pkg;

  localparam int ChW      = 8;     // width of one color channel
  localparam int HueW     = 13;    // hue in 1/16 degree
  localparam int QuoW     = 10;    // quotient bits resolved by the divider chain
  localparam int NumCells = QuoW;  // one cell per quotient bit
  localparam int RemHW    = 18;    // 960 * 255 fits in 18 bits
  localparam int RemSW    = 16;    // 255 * 255 fits in 16 bits

  localparam logic [HueW-1:0] HueGreenBase = 13'd1920;
  localparam logic [HueW-1:0] HueBlueBase  = 13'd3840;
  localparam logic [HueW:0]   HueFull      = 14'd5760;

  // which channel is the largest; picks the hue base
  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } base_sel_t;

  // word handed from cell to cell
  typedef struct packed {
    logic [RemHW-1:0] rem_h;   // partial remainder of 960*|diff| / delta
    logic [RemSW-1:0] rem_s;   // partial remainder of 255*delta / max
    logic [QuoW-1:0]  q_h;
    logic [QuoW-1:0]  q_s;
    logic [ChW-1:0]   delta;
    logic [ChW-1:0]   hi;
    base_sel_t        base;
    logic             neg;     // channel difference was negative
    logic             grey;    // delta is zero
  } div_word_t;

endpackage

@@ hdl/rhsv_if.sv @@
// rhsv_if: valid/ready channel interfaces for pixels in and HSV words out.
// Depends on rhsv_pkg for widths.

interface rhsv_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [rhsv_pkg::ChW-1:0]   red;
  logic [rhsv_pkg::ChW-1:0]   green;
  logic [rhsv_pkg::ChW-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsv_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [rhsv_pkg::HueW-1:0]  hue;
  logic [rhsv_pkg::ChW-1:0]   saturation;
  logic [rhsv_pkg::ChW-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

@@ hdl/rhsv_front.sv @@
// rhsv_front: max/min search, hue sector pick and the two dividends.
// Depends on rhsv_pkg and rhsv_if; feeds the first divider cell.

module rhsv_front (
  input  logic                clk,
  input  logic                rst,
  rhsv_pixel_if.sink          pixel,
  output logic                out_valid,
  input  logic                out_ready,
  output rhsv_pkg::div_word_t out_word
);

  logic [rhsv_pkg::ChW-1:0]   hi;
  logic [rhsv_pkg::ChW-1:0]   lo;
  logic [rhsv_pkg::ChW-1:0]   delta;
  logic [rhsv_pkg::ChW:0]     diff;      // signed, two's complement
  logic [rhsv_pkg::ChW-1:0]   mag;
  rhsv_pkg::base_sel_t        base;
  rhsv_pkg::div_word_t        word_next;

  assign pixel.ready = !out_valid || out_ready;

  always_comb begin
    hi = pixel.red;
    if (pixel.green > hi) hi = pixel.green;
    if (pixel.blue > hi) hi = pixel.blue;
    lo = pixel.red;
    if (pixel.green < lo) lo = pixel.green;
    if (pixel.blue < lo) lo = pixel.blue;
    delta = hi - lo;

    if (pixel.red == hi) begin
      base = rhsv_pkg::BASE_RED;
      diff = {1'b0, pixel.green} - {1'b0, pixel.blue};
    end else if (pixel.green == hi) begin
      base = rhsv_pkg::BASE_GREEN;
      diff = {1'b0, pixel.blue} - {1'b0, pixel.red};
    end else begin
      base = rhsv_pkg::BASE_BLUE;
      diff = {1'b0, pixel.red} - {1'b0, pixel.green};
    end
    mag = diff[rhsv_pkg::ChW] ? rhsv_pkg::ChW'(-diff) : diff[rhsv_pkg::ChW-1:0];

    word_next       = '0;
    // 960*x = (x << 10) - (x << 6); 255*x = (x << 8) - x
    word_next.rem_h = (rhsv_pkg::RemHW'(mag) << 10) - (rhsv_pkg::RemHW'(mag) << 6);
    word_next.rem_s = (rhsv_pkg::RemSW'(delta) << 8) - rhsv_pkg::RemSW'(delta);
    word_next.delta = delta;
    word_next.hi    = hi;
    word_next.base  = base;
    word_next.neg   = diff[rhsv_pkg::ChW];
    word_next.grey  = (delta == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pixel.ready) begin
      out_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready && pixel.valid) begin
      out_word <= word_next;
    end
  end

endmodule

@@ hdl/rhsv_div_cell.sv @@
// rhsv_div_cell: one restoring-division step for both hue and saturation.
// Depends on rhsv_pkg; chained NumCells deep, SHIFT counts down to zero.

module rhsv_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhsv_pkg::div_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rhsv_pkg::div_word_t out_word
);

  localparam int CmpW = rhsv_pkg::RemHW;

  logic [CmpW-1:0]     dh;
  logic [CmpW-1:0]     ds;
  logic [CmpW-1:0]     rs_ext;
  rhsv_pkg::div_word_t word_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dh        = CmpW'(in_word.delta) << SHIFT;
    ds        = CmpW'(in_word.hi) << SHIFT;
    rs_ext    = CmpW'(in_word.rem_s);
    word_next = in_word;
    if (in_word.rem_h >= dh) begin
      word_next.rem_h      = in_word.rem_h - dh;
      word_next.q_h[SHIFT] = 1'b1;
    end
    if (rs_ext >= ds) begin
      word_next.rem_s      = rhsv_pkg::RemSW'(rs_ext - ds);
      word_next.q_s[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

@@ hdl/rhsv_finish.sv @@
// rhsv_finish: adds the hue base, wraps negative hue, output register.
// Depends on rhsv_pkg and rhsv_if; takes the last divider cell's word.

module rhsv_finish (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhsv_pkg::div_word_t in_word,
  rhsv_hsv_if.source          hsv
);

  logic [rhsv_pkg::HueW:0]    base_ext;
  logic [rhsv_pkg::HueW:0]    offs;
  logic [rhsv_pkg::HueW:0]    sum;
  logic [rhsv_pkg::HueW-1:0]  hue_next;
  logic [rhsv_pkg::ChW-1:0]   sat_next;

  assign in_ready = !hsv.valid || hsv.ready;

  always_comb begin
    case (in_word.base)
      rhsv_pkg::BASE_GREEN: base_ext = {1'b0, rhsv_pkg::HueGreenBase};
      rhsv_pkg::BASE_BLUE:  base_ext = {1'b0, rhsv_pkg::HueBlueBase};
      default:              base_ext = '0;
    endcase
    offs = (rhsv_pkg::HueW + 1)'(in_word.q_h);
    sum  = in_word.neg ? base_ext - offs : base_ext + offs;
    if (sum[rhsv_pkg::HueW]) begin
      sum = sum + rhsv_pkg::HueFull;
    end
    hue_next = in_word.grey ? '0 : sum[rhsv_pkg::HueW-1:0];
    sat_next = in_word.grey ? '0 : in_word.q_s[rhsv_pkg::ChW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv.valid <= 1'b0;
    end else if (in_ready) begin
      hsv.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hsv.hue        <= hue_next;
      hsv.saturation <= sat_next;
      hsv.brightness <= in_word.hi;
    end
  end

endmodule

@@ hdl/rgb_to_hsv_converter_unit.sv @@
// rgb_to_hsv_converter_unit: top level of the hexcone RGB to HSV converter.
// Depends on rhsv_pkg, rhsv_if, rhsv_front, rhsv_div_cell and rhsv_finish.
//
//   channel  dir  word                          handshake
//   pixel    in   red, green, blue (8b each)    valid/ready
//   hsv      out  hue (13b), saturation (8b),   valid/ready
//                 brightness (8b)
//
// One pixel per clock sustained while the output is ready; the stages are the front
// stage, one cell per quotient bit of the 10-cell divider chain, and the output register.
// Every stage has its own valid and registers whenever the next one can
// take it, so bubbles close up and a stalled output holds only what is
// queued behind it. rst is synchronous and clears the valid bits only.

module rgb_to_hsv_converter_unit (
  input  logic         clk,
  input  logic         rst,
  rhsv_pixel_if.sink   pixel,
  rhsv_hsv_if.source   hsv
);

  localparam int N = rhsv_pkg::NumCells;

  logic                chain_valid [0:N];
  logic                chain_ready [0:N];
  rhsv_pkg::div_word_t chain_word  [0:N];

  rhsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_word  (chain_word[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    rhsv_div_cell #(
      .SHIFT (rhsv_pkg::QuoW - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_word   (chain_word[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_word  (chain_word[k+1])
    );
  end

  rhsv_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[N]),
    .in_ready (chain_ready[N]),
    .in_word  (chain_word[N]),
    .hsv      (hsv)
  );

`ifndef NO_ASSERTIONS
  // hue quotient never exceeds one sector
  a_hue_quot: assert property (@(posedge clk) disable iff (rst)
    chain_valid[N] && !chain_word[N].grey |-> chain_word[N].q_h <= 10'd960)
    else $error("hue quotient out of range");

  // saturation quotient fits in a channel
  a_sat_quot: assert property (@(posedge clk) disable iff (rst)
    chain_valid[N] && !chain_word[N].grey |-> chain_word[N].q_s[9:8] == 2'b00)
    else $error("saturation quotient overflow");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> hsv.hue < 13'd5760)
    else $error("hue beyond full circle");

  // black pixel is grey
  a_black: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && hsv.brightness == 8'd0 |-> hsv.hue == 13'd0 && hsv.saturation == 8'd0)
    else $error("black pixel with hue or saturation");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for rgb_to_hsv_converter_unit, with pixels in and HSV words out.
// Depends on rhsv_pkg, rhsv_if and the converter RTL. Words are checked against typed rows or an inline predictor.

module tb;

  localparam int ChW         = rhsv_pkg::ChW;
  localparam int HueW        = rhsv_pkg::HueW;
  localparam int HueSector   = 960;
  localparam int SatScale    = 255;
  localparam int HoldCycles  = 80;    // long receiver hold-off
  localparam int DrainCycles = 30;    // > pipeline latency
  localparam int QuietLimit  = 2000;
  localparam int MaxReports  = 20;
  localparam int NumRows     = 22;
  localparam int ExpDepth    = 4096;  // ring of expected words, indexed by counts

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [ChW-1:0]  sat;
    logic [ChW-1:0]  bright;
  } hsv_word_t;

  typedef struct packed {
    logic [ChW-1:0]  r;
    logic [ChW-1:0]  g;
    logic [ChW-1:0]  b;
    logic            typed;   // hue/sat/bright below are valid
    logic [HueW-1:0] hue;
    logic [ChW-1:0]  sat;
    logic [ChW-1:0]  bright;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhsv_pixel_if pixel_ch();
  rhsv_hsv_if   hsv_ch();

  rgb_to_hsv_converter_unit dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .hsv   (hsv_ch)
  );

  always #5 clk = ~clk;

  hsv_word_t expected_words [ExpDepth];
  bit idle_on  = 1'b0;
  bit hold_req = 1'b0;
  int pixels_sent   = 0;
  int words_checked = 0;
  int grey_sent     = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  // grey, primaries, ties, hue wrap and truncation corners; typed where obvious
  pixel_row_t directed_rows [NumRows] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 13'd0,    8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 13'd0,    8'd0,   8'd255},
    '{8'd128, 8'd128, 8'd128, 1'b1, 13'd0,    8'd0,   8'd128},
    '{8'd255, 8'd0,   8'd0,   1'b1, 13'd0,    8'd255, 8'd255},
    '{8'd0,   8'd255, 8'd0,   1'b1, 13'd1920, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd255, 1'b1, 13'd3840, 8'd255, 8'd255},
    '{8'd255, 8'd255, 8'd0,   1'b1, 13'd960,  8'd255, 8'd255},
    '{8'd0,   8'd255, 8'd255, 1'b1, 13'd2880, 8'd255, 8'd255},
    '{8'd255, 8'd0,   8'd255, 1'b1, 13'd4800, 8'd255, 8'd255},
    '{8'd1,   8'd0,   8'd0,   1'b1, 13'd0,    8'd255, 8'd1},
    '{8'd0,   8'd0,   8'd1,   1'b1, 13'd3840, 8'd255, 8'd1},
    '{8'd255, 8'd0,   8'd1,   1'b1, 13'd5757, 8'd255, 8'd255},
    '{8'd1,   8'd1,   8'd0,   1'b1, 13'd960,  8'd255, 8'd1},
    '{8'd10,  8'd200, 8'd30,  1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd200, 8'd10,  8'd100, 1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd37,  8'd90,  8'd250, 1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd254, 8'd255, 8'd253, 1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd100, 8'd50,  8'd50,  1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd1,   8'd2,   8'd3,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd255, 8'd128, 8'd0,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd0,   8'd128, 8'd255, 1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd255, 8'd254, 8'd255, 1'b0, 13'd0,    8'd0,   8'd0}
  };

  function automatic hsv_word_t predict_hsv(input logic [ChW-1:0] r, g, b);
    int hi, lo, delta, diff, hue_acc;
    rhsv_pkg::base_sel_t sel;
    hsv_word_t w;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    w = '0;
    w.bright = hi[ChW-1:0];
    if (delta != 0) begin
      w.sat = ChW'((SatScale * delta) / hi);
      // red wins ties over green and blue, green over blue
      if (r == hi) sel = rhsv_pkg::BASE_RED;
      else if (g == hi) sel = rhsv_pkg::BASE_GREEN;
      else sel = rhsv_pkg::BASE_BLUE;
      case (sel)
        rhsv_pkg::BASE_RED: begin
          hue_acc = 0;
          diff = int'(g) - int'(b);
        end
        rhsv_pkg::BASE_GREEN: begin
          hue_acc = int'(rhsv_pkg::HueGreenBase);
          diff = int'(b) - int'(r);
        end
        default: begin
          hue_acc = int'(rhsv_pkg::HueBlueBase);
          diff = int'(r) - int'(g);
        end
      endcase
      hue_acc = hue_acc + (HueSector * diff) / delta;  // truncates toward zero
      if (hue_acc < 0) hue_acc = hue_acc + int'(rhsv_pkg::HueFull);
      w.hue = HueW'(hue_acc);
    end
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(input logic [ChW-1:0] r, g, b, input logic typed,
                            input hsv_word_t typed_word);
    // each idle cycle taken with 1-in-4 odds, so about a quarter of the cycles idle
    while (idle_on && $urandom_range(99) < 25) begin
      pixel_ch.valid = 1'b0;
      pixel_ch.red   = ChW'($urandom);
      pixel_ch.green = ChW'($urandom);
      pixel_ch.blue  = ChW'($urandom);
      @(negedge clk);
    end
    pixel_ch.valid = 1'b1;
    pixel_ch.red   = r;
    pixel_ch.green = g;
    pixel_ch.blue  = b;
    do @(posedge clk); while (pixel_ch.ready !== 1'b1);
    expected_words[pixels_sent % ExpDepth] = typed ? typed_word : predict_hsv(r, g, b);
    pixels_sent++;
    if (r == g && g == b) grey_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    logic [ChW-1:0] r, g, b, v, lo;
    repeat (count) begin
      case ($urandom_range(9))
        0: begin
          v = ChW'($urandom);
          r = v;
          g = v;
          b = v;
        end
        1: begin
          v  = ChW'($urandom_range(1, 255));
          lo = ChW'($urandom_range(0, v - 1));
          case ($urandom_range(2))
            0: begin r = v;  g = v;  b = lo; end
            1: begin r = v;  g = lo; b = v;  end
            default: begin r = lo; g = v; b = v; end
          endcase
        end
        2: begin
          // near grey: tiny delta stresses the hue divide
          v = ChW'($urandom);
          r = v;
          g = v ^ ChW'($urandom_range(3));
          b = v ^ ChW'($urandom_range(3));
        end
        3: begin
          r = $urandom_range(1) ? 8'd255 - ChW'($urandom_range(1)) : ChW'($urandom_range(1));
          g = $urandom_range(1) ? 8'd255 - ChW'($urandom_range(1)) : ChW'($urandom_range(1));
          b = $urandom_range(1) ? 8'd255 - ChW'($urandom_range(1)) : ChW'($urandom_range(1));
        end
        default: begin
          r = ChW'($urandom);
          g = ChW'($urandom);
          b = ChW'($urandom);
        end
      endcase
      send_pixel(r, g, b, 1'b0, '0);
    end
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    hsv_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hsv_ch.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        hsv_ch.ready = !idle_on || ($urandom_range(99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    hsv_word_t want;
    if (!rst && hsv_ch.valid === 1'b1 && hsv_ch.ready === 1'b1) begin
      if (words_checked >= pixels_sent) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected HSV word hue=%0d sat=%0d bright=%0d", $time,
                   hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
      end else begin
        want = expected_words[words_checked % ExpDepth];
        words_checked++;
        if (hsv_ch.hue !== want.hue) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: hue expected %0d got %0d", $time, want.hue, hsv_ch.hue);
        end
        if (hsv_ch.saturation !== want.sat) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: saturation expected %0d got %0d", $time, want.sat,
                     hsv_ch.saturation);
        end
        if (hsv_ch.brightness !== want.bright) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: brightness expected %0d got %0d", $time, want.bright,
                     hsv_ch.brightness);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) ||
        (hsv_ch.valid === 1'b1 && hsv_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d words outstanding", $time,
                 quiet_cycles, pixels_sent - words_checked);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    hsv_word_t typed_word;
    pixel_ch.valid = 1'b0;
    pixel_ch.red   = '0;
    pixel_ch.green = '0;
    pixel_ch.blue  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NumRows; i++) begin
      typed_word = '{directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].bright};
      send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                 directed_rows[i].typed, typed_word);
    end

    idle_on = 1'b1;
    send_random(700);
    idle_on = 1'b0;
    send_random(400);
    // output held off while input keeps streaming; pipeline fills and stalls
    hold_req = 1'b1;
    send_random(150);
    idle_on = 1'b1;
    send_random(750);
    pixel_ch.valid = 1'b0;

    wait (words_checked == pixels_sent);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d pixels (%0d grey), checked %0d HSV words, %0d mismatches;",
             pixels_sent, grey_sent, words_checked, mismatches);
    $display("run covered directed corners, random back-pressure and a long output stall.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rhsv_pkg.sv
hdl/rhsv_if.sv
hdl/rhsv_front.sv
hdl/rhsv_div_cell.sv
hdl/rhsv_finish.sv
hdl/rgb_to_hsv_converter_unit.sv
test/tb.sv
